>>> hw/rtl/utf8v_pkg.sv
// Shared constants, types and byte-classification functions for the UTF-8 text validator.
// No dependencies; the validator top level uses this package by scoped names.
`default_nettype none

package utf8v_pkg;

    localparam int unsigned LinesWidth   = 16;
    localparam int unsigned DataWidth    = 32;
    localparam int unsigned AddrWidth    = 3;
    localparam logic [LinesWidth-1:0] LinesResetValue = 16'd10;

    // register index, taken from paddr[2]
    localparam logic RegLinesToCheck = 1'b0;

    // range allowed for the first continuation byte
    localparam logic [2:0] KindNormal = 3'd0;  // 80..BF
    localparam logic [2:0] KindE0     = 3'd1;  // A0..BF
    localparam logic [2:0] KindED     = 3'd2;  // 80..9F
    localparam logic [2:0] KindF0     = 3'd3;  // 90..BF
    localparam logic [2:0] KindF4     = 3'd4;  // 80..8F

    localparam logic [7:0] ByteTab      = 8'h09;
    localparam logic [7:0] ByteLf       = 8'h0A;
    localparam logic [7:0] ByteCr       = 8'h0D;
    localparam logic [7:0] BytePrintLo  = 8'h20;
    localparam logic [7:0] BytePrintHi  = 8'h7E;
    localparam logic [7:0] ByteContLo   = 8'h80;
    localparam logic [7:0] ByteContHi   = 8'hBF;
    localparam logic [7:0] ByteContMid  = 8'h8F;
    localparam logic [7:0] ByteCont9F   = 8'h9F;
    localparam logic [7:0] ByteCont90   = 8'h90;
    localparam logic [7:0] ByteContA0   = 8'hA0;
    localparam logic [7:0] ByteLead2Lo  = 8'hC2;
    localparam logic [7:0] ByteLead2Hi  = 8'hDF;
    localparam logic [7:0] ByteE0       = 8'hE0;
    localparam logic [7:0] ByteED       = 8'hED;
    localparam logic [7:0] ByteEF       = 8'hEF;
    localparam logic [7:0] ByteF0       = 8'hF0;
    localparam logic [7:0] ByteF3       = 8'hF3;
    localparam logic [7:0] ByteF4       = 8'hF4;
    localparam logic [7:0] ByteBom1     = 8'hEF;
    localparam logic [7:0] ByteBom2     = 8'hBB;
    localparam logic [7:0] ByteBom3     = 8'hBF;

    typedef struct packed {
        logic       bad;
        logic       newline;
        logic       start;
        logic [1:0] left;
        logic [2:0] kind;
    } lead_class_t;

    function automatic logic cont_ok(input logic [7:0] b, input logic [2:0] kind);
        logic ok;
        unique case (kind)
            KindE0:  ok = (b >= ByteContA0) && (b <= ByteContHi);
            KindED:  ok = (b >= ByteContLo) && (b <= ByteCont9F);
            KindF0:  ok = (b >= ByteCont90) && (b <= ByteContHi);
            KindF4:  ok = (b >= ByteContLo) && (b <= ByteContMid);
            default: ok = (b >= ByteContLo) && (b <= ByteContHi);
        endcase
        return ok;
    endfunction

    function automatic lead_class_t classify(input logic [7:0] b);
        lead_class_t c;
        c = '0;
        priority if (b == ByteLf) begin
            c.newline = 1'b1;
        end
        else if (b == ByteTab || b == ByteCr || (b >= BytePrintLo && b <= BytePrintHi)) begin
            c = '0;
        end
        else if (b >= ByteLead2Lo && b <= ByteLead2Hi) begin
            c.start = 1'b1; c.left = 2'd1; c.kind = KindNormal;
        end
        else if (b == ByteE0) begin
            c.start = 1'b1; c.left = 2'd2; c.kind = KindE0;
        end
        else if (b == ByteED) begin
            c.start = 1'b1; c.left = 2'd2; c.kind = KindED;
        end
        else if (b > ByteE0 && b <= ByteEF) begin
            c.start = 1'b1; c.left = 2'd2; c.kind = KindNormal;
        end
        else if (b == ByteF0) begin
            c.start = 1'b1; c.left = 2'd3; c.kind = KindF0;
        end
        else if (b > ByteF0 && b <= ByteF3) begin
            c.start = 1'b1; c.left = 2'd3; c.kind = KindNormal;
        end
        else if (b == ByteF4) begin
            c.start = 1'b1; c.left = 2'd3; c.kind = KindF4;
        end
        else begin
            c.bad = 1'b1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/utf8_text_validator.sv
// Top level of the streaming UTF-8 text validator: byte checker, BOM detector, APB register.
// Depends on utf8v_pkg for constants, the lead-byte classifier and continuation checks.
//
// Usage:
//   Input channel (in_valid/in_ready): each request carries data_byte and end_of_text.
//   A request with end_of_text low is one byte of the text and yields nothing; a request
//   with end_of_text high ends the text and yields exactly one verdict on the output
//   channel (out_valid/out_ready): text_is_utf8 and bom_found.
//   Every byte is checked and folded into the running state in the cycle it is accepted,
//   so one request is taken every clock cycle unless an end request meets a waiting verdict.
//   The registered verdict shows on out_valid in the cycle after its end request is taken.
//   While a verdict waits (out_valid high, out_ready low) byte requests are still taken;
//   only a further end request is held off until the waiting verdict has gone.
//   lines_to_check (APB, byte address 0) sets how many LF-separated lines are checked;
//   bytes after that are only watched for the byte-order mark prefix.
//   Reset (rst_n low, asynchronous) clears the text state and output valid and loads
//   lines_to_check with 10. All text state clears again after each end request.
`default_nettype none

module utf8_text_validator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input channel
    input  wire logic                                in_valid,
    output      logic                                in_ready,
    input  wire logic [7:0]                          data_byte,
    input  wire logic                                end_of_text,
    // output channel
    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      logic                                text_is_utf8,
    output      logic                                bom_found,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [utf8v_pkg::AddrWidth-1:0]     paddr,
    input  wire logic [utf8v_pkg::DataWidth-1:0]     pwdata,
    output      logic [utf8v_pkg::DataWidth-1:0]     prdata,
    output      logic                                pready
);

    localparam int unsigned LW = utf8v_pkg::LinesWidth;

    // configuration
    logic [LW-1:0] lines_to_check_reg;

    // text state
    logic [1:0]    left_reg,    left_next;
    logic [2:0]    kind_reg,    kind_next;
    logic          first_reg,   first_next;
    logic          err_reg,     err_next;
    logic [LW-1:0] lines_reg,   lines_next;
    logic [1:0]    prefix_reg,  prefix_next;
    logic          bom_reg,     bom_next;

    // output register
    logic          out_valid_reg;
    logic          utf8_reg;
    logic          bomf_reg;

    logic                   in_fire;
    logic                   cfg_write;
    logic                   checking;
    logic [7:0]             bom_expect;
    logic [2:0]             cont_kind;
    utf8v_pkg::lead_class_t lead;
    logic                   verdict_bom;
    logic                   verdict_ok;

    // Take bytes even while a verdict waits; hold an end request until the slot frees.
    assign in_ready  = !end_of_text || !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    assign out_valid    = out_valid_reg;
    assign text_is_utf8 = utf8_reg;
    assign bom_found    = bomf_reg;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == utf8v_pkg::RegLinesToCheck);
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == utf8v_pkg::RegLinesToCheck)
        begin
            prdata[LW-1:0] = lines_to_check_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_to_check_reg <= utf8v_pkg::LinesResetValue;
        end
        else if (cfg_write)
        begin
            lines_to_check_reg <= pwdata[LW-1:0];
        end
    end

    // ---------------------------------------------------------------- byte path
    // Checking stays on while the completed line count is below the limit.
    assign checking = lines_reg < lines_to_check_reg;

    always_comb
    begin
        unique case (prefix_reg)
            2'd0:    bom_expect = utf8v_pkg::ByteBom1;
            2'd1:    bom_expect = utf8v_pkg::ByteBom2;
            default: bom_expect = utf8v_pkg::ByteBom3;
        endcase
    end

    // Only the first continuation byte of a sequence has a narrowed range.
    assign cont_kind   = first_reg ? kind_reg : utf8v_pkg::KindNormal;
    assign lead        = utf8v_pkg::classify(data_byte);
    assign verdict_bom = bom_reg && (prefix_reg == 2'd3);
    assign verdict_ok  = !err_reg && !(checking && (left_reg != 2'd0));

    always_comb
    begin
        left_next   = left_reg;
        kind_next   = kind_reg;
        first_next  = first_reg;
        err_next    = err_reg;
        lines_next  = lines_reg;
        prefix_next = prefix_reg;
        bom_next    = bom_reg;

        if (end_of_text)
        begin
            // drop all text state for the next text
            left_next   = 2'd0;
            kind_next   = utf8v_pkg::KindNormal;
            first_next  = 1'b0;
            err_next    = 1'b0;
            lines_next  = '0;
            prefix_next = 2'd0;
            bom_next    = 1'b1;
        end
        else
        begin
            // BOM watch over the first three bytes, whatever the checker does
            if (prefix_reg != 2'd3)
            begin
                if (data_byte != bom_expect)
                begin
                    bom_next = 1'b0;
                end
                prefix_next = prefix_reg + 2'd1;
            end

            if (!err_reg && checking)
            begin
                if (left_reg != 2'd0)
                begin
                    // inside a sequence: a newline cuts it, a bad continuation fails it
                    if (data_byte == utf8v_pkg::ByteLf
                        || !utf8v_pkg::cont_ok(data_byte, cont_kind))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        left_next  = left_reg - 2'd1;
                        first_next = 1'b0;
                    end
                end
                else
                begin
                    if (lead.newline)
                    begin
                        lines_next = lines_reg + LW'(1);
                    end
                    if (lead.bad)
                    begin
                        err_next = 1'b1;
                    end
                    if (lead.start)
                    begin
                        left_next  = lead.left;
                        kind_next  = lead.kind;
                        first_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= 2'd0;
            kind_reg   <= utf8v_pkg::KindNormal;
            first_reg  <= 1'b0;
            err_reg    <= 1'b0;
            lines_reg  <= '0;
            prefix_reg <= 2'd0;
            bom_reg    <= 1'b1;
        end
        else if (in_fire)
        begin
            left_reg   <= left_next;
            kind_reg   <= kind_next;
            first_reg  <= first_next;
            err_reg    <= err_next;
            lines_reg  <= lines_next;
            prefix_reg <= prefix_next;
            bom_reg    <= bom_next;
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && end_of_text)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && end_of_text)
        begin
            utf8_reg <= verdict_bom || verdict_ok;
            bomf_reg <= verdict_bom;
        end
    end

    // ---------------------------------------------------------------- assertions
    a_end_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_text) |=> out_valid)
        else $error("end request did not load a verdict");

    a_bom_implies_utf8: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bom_found) |-> text_is_utf8)
        else $error("BOM verdict without acceptance");

    a_first_in_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg |-> (left_reg != 2'd0))
        else $error("first-continuation flag set outside a sequence");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_text) |=> (left_reg == 2'd0 && !err_reg && prefix_reg == 2'd0))
        else $error("text state not cleared after end request");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_text_validator: directed and random texts go through the
// request channel, every verdict is predicted here and compared field by field on arrival.
// Depends on utf8v_pkg (address and range-kind constants) and the utf8_text_validator RTL.

module tb;

    // cycles with no request or verdict taken before the run is declared hung
    localparam int unsigned WatchdogLimit  = 3000;
    // cycles allowed after the last verdict for byte requests still in the pipe
    localparam int unsigned SettleCycles   = 8;
    // long receiver hold-off, long enough for the block to stall its input
    localparam int unsigned LongHoldCycles = 300;
    localparam int unsigned MaxPrinted     = 40;

    localparam logic [utf8v_pkg::AddrWidth-1:0] LinesAddr = {utf8v_pkg::RegLinesToCheck, 2'b00};
    localparam logic [7:0]  LineFeed = 8'h0A;
    localparam logic [23:0] BomSeq   = 24'hEFBBBF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_request_t;

    typedef struct packed {
        logic utf8;
        logic bom;
    } verdict_t;

    // ---------------------------------------------------------------- DUT signals
    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                in_valid    = 1'b0;
    logic                                in_ready;
    logic [7:0]                          data_byte   = 8'h00;
    logic                                end_of_text = 1'b0;
    logic                                out_valid;
    logic                                out_ready   = 1'b0;
    logic                                text_is_utf8;
    logic                                bom_found;
    logic                                psel        = 1'b0;
    logic                                penable     = 1'b0;
    logic                                pwrite      = 1'b0;
    logic [utf8v_pkg::AddrWidth-1:0]     paddr       = '0;
    logic [utf8v_pkg::DataWidth-1:0]     pwdata      = '0;
    logic [utf8v_pkg::DataWidth-1:0]     prdata;
    logic                                pready;

    // ---------------------------------------------------------------- testbench state
    text_request_t byte_requests[$];      // requests waiting to be offered
    verdict_t      expected_verdicts[$];  // verdicts owed by the block, oldest first
    text_request_t next_req;
    int unsigned   items_queued  = 0;
    int unsigned   mismatches    = 0;
    int unsigned   verdicts_seen = 0;
    int unsigned   idle_cycles   = 0;
    int unsigned   send_gap      = 0;
    int unsigned   send_steady   = 0;
    int unsigned   ready_gap     = 0;
    int unsigned   ready_steady  = 0;
    int unsigned   hold_left     = 0;

    // mirror of the validator's text state and its line limit
    logic [15:0] lines_limit = 16'd10;
    logic [1:0]  seq_left;
    logic [2:0]  first_kind;
    logic        at_first;
    logic        err_sticky;
    logic [15:0] lines_done;
    logic [1:0]  prefix_pos;
    logic        bom_match;

    utf8_text_validator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .text_is_utf8 (text_is_utf8),
        .bom_found    (bom_found),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------- helpers
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MaxPrinted)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Gap before the next request or ready; mostly short, now and then long, and
    // occasionally a steady run with no gaps at all.
    function automatic int unsigned next_gap(inout int unsigned steady);
        int unsigned roll;
        if (steady != 0)
        begin
            steady--;
            return 0;
        end
        roll = $urandom_range(99, 0);
        if (roll < 2)
        begin
            steady = $urandom_range(120, 40);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [7:0] rnd_byte(input logic [7:0] lo, input logic [7:0] hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    task automatic clear_text_state();
        seq_left   = 2'd0;
        first_kind = utf8v_pkg::KindNormal;
        at_first   = 1'b0;
        err_sticky = 1'b0;
        lines_done = 16'd0;
        prefix_pos = 2'd0;
        bom_match  = 1'b1;
    endtask

    task automatic open_sequence(input logic [1:0] left, input logic [2:0] kind);
        seq_left   = left;
        first_kind = kind;
        at_first   = 1'b1;
    endtask

    // Fold one accepted request into the mirrored state; an end request owes a verdict.
    task automatic track_text_request(input logic [7:0] b, input logic last);
        verdict_t   v;
        logic       checking;
        logic       in_range;
        logic [2:0] range_kind;
        if (last)
        begin
            checking = (lines_done < lines_limit);
            v.bom    = bom_match && (prefix_pos == 2'd3);
            // a sequence left open only counts while lines are still being checked
            v.utf8   = v.bom || (!err_sticky && !(checking && seq_left != 2'd0));
            expected_verdicts.push_back(v);
            clear_text_state();
        end
        else
        begin
            // the mark is watched on the first three bytes whatever the line limit
            if (prefix_pos != 2'd3)
            begin
                if (b != BomSeq[23 - 8 * prefix_pos -: 8])
                    bom_match = 1'b0;
                prefix_pos++;
            end
            if (!err_sticky && lines_done < lines_limit)
            begin
                if (seq_left != 2'd0)
                begin
                    // only the first continuation byte has a narrowed range
                    range_kind = at_first ? first_kind : utf8v_pkg::KindNormal;
                    case (range_kind)
                        utf8v_pkg::KindE0: in_range = (b >= 8'hA0 && b <= 8'hBF);
                        utf8v_pkg::KindED: in_range = (b >= 8'h80 && b <= 8'h9F);
                        utf8v_pkg::KindF0: in_range = (b >= 8'h90 && b <= 8'hBF);
                        utf8v_pkg::KindF4: in_range = (b >= 8'h80 && b <= 8'h8F);
                        default:           in_range = (b >= 8'h80 && b <= 8'hBF);
                    endcase
                    if (b == LineFeed || !in_range)
                        err_sticky = 1'b1;
                    else
                    begin
                        seq_left--;
                        at_first = 1'b0;
                    end
                end
                else if (b == LineFeed)
                    lines_done++;
                else if (b == 8'h09 || b == 8'h0D || (b >= 8'h20 && b <= 8'h7E))
                begin
                    // single-byte character: nothing to track
                end
                else if (b >= 8'hC2 && b <= 8'hDF)
                    open_sequence(2'd1, utf8v_pkg::KindNormal);
                else if (b == 8'hE0)
                    open_sequence(2'd2, utf8v_pkg::KindE0);
                else if (b == 8'hED)
                    open_sequence(2'd2, utf8v_pkg::KindED);
                else if (b >= 8'hE1 && b <= 8'hEF)
                    open_sequence(2'd2, utf8v_pkg::KindNormal);
                else if (b == 8'hF0)
                    open_sequence(2'd3, utf8v_pkg::KindF0);
                else if (b >= 8'hF1 && b <= 8'hF3)
                    open_sequence(2'd3, utf8v_pkg::KindNormal);
                else if (b == 8'hF4)
                    open_sequence(2'd3, utf8v_pkg::KindF4);
                else
                    err_sticky = 1'b1;
            end
        end
    endtask

    task automatic next_verdict_check(input verdict_t want);
        if (text_is_utf8 !== want.utf8)
            report_mismatch($sformatf("verdict %0d: text_is_utf8 %0b, expected %0b",
                                      verdicts_seen, text_is_utf8, want.utf8));
        if (bom_found !== want.bom)
            report_mismatch($sformatf("verdict %0d: bom_found %0b, expected %0b",
                                      verdicts_seen, bom_found, want.bom));
    endtask

    task automatic queue_byte(input logic [7:0] b);
        byte_requests.push_back('{data: b, last: 1'b0});
        items_queued++;
    endtask

    // the byte riding on an end request is ignored, so make it random
    task automatic queue_end();
        byte_requests.push_back('{data: rnd_byte(8'h00, 8'hFF), last: 1'b1});
        items_queued++;
    endtask

    // One random text: mostly well-formed characters, sometimes with one flaw planted,
    // sometimes led by the byte-order mark, and now and then plain noise.
    task automatic queue_random_text();
        int unsigned n_chars;
        int unsigned flaw_at;
        int unsigned i;
        int unsigned pick;
        int unsigned roll;
        logic        flawed;
        logic [7:0]  lead;
        pick = $urandom_range(19, 0);
        if (pick == 0)
        begin
            n_chars = $urandom_range(12, 0);
            repeat (n_chars) queue_byte(rnd_byte(8'h00, 8'hFF));
            queue_end();
        end
        else
        begin
            if (pick < 5)
            begin
                queue_byte(8'hEF);
                queue_byte(8'hBB);
                queue_byte(8'hBF);
            end
            else if (pick == 5)
            begin
                // partial mark: it opens a sequence that the next character may break
                queue_byte(8'hEF);
                if ($urandom_range(1, 0) != 0)
                    queue_byte(8'hBB);
            end
            n_chars = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 0);
            flawed  = ($urandom_range(2, 0) == 0);
            flaw_at = $urandom_range(n_chars, 0);
            for (i = 0; i <= n_chars; i++)
            begin
                if (flawed && i == flaw_at)
                begin
                    case ($urandom_range(9, 0))
                        0: queue_byte(rnd_byte(8'h80, 8'hBF));   // stray continuation
                        1:
                        begin
                            // leads that can never start a sequence: C0, C1, F5..FF
                            roll = $urandom_range(12, 0);
                            queue_byte((roll < 2) ? 8'(8'hC0 + roll) : 8'(8'hF5 + roll - 2));
                        end
                        2:
                        begin
                            // overlong three-byte form
                            queue_byte(8'hE0);
                            queue_byte(rnd_byte(8'h80, 8'h9F));
                            queue_byte(rnd_byte(8'h80, 8'hBF));
                        end
                        3:
                        begin
                            // surrogate
                            queue_byte(8'hED);
                            queue_byte(rnd_byte(8'hA0, 8'hBF));
                            queue_byte(rnd_byte(8'h80, 8'hBF));
                        end
                        4:
                        begin
                            // overlong four-byte form
                            queue_byte(8'hF0);
                            queue_byte(rnd_byte(8'h80, 8'h8F));
                            queue_byte(rnd_byte(8'h80, 8'hBF));
                            queue_byte(rnd_byte(8'h80, 8'hBF));
                        end
                        5:
                        begin
                            // above U+10FFFF
                            queue_byte(8'hF4);
                            queue_byte(rnd_byte(8'h90, 8'hBF));
                            queue_byte(rnd_byte(8'h80, 8'hBF));
                            queue_byte(rnd_byte(8'h80, 8'hBF));
                        end
                        6:
                        begin
                            // sequence cut by a newline
                            queue_byte(rnd_byte(8'hC2, 8'hDF));
                            queue_byte(LineFeed);
                        end
                        7:
                        begin
                            // sequence cut by a plain character
                            queue_byte(rnd_byte(8'hE1, 8'hEC));
                            queue_byte(rnd_byte(8'h80, 8'hBF));
                            queue_byte(rnd_byte(8'h20, 8'h7E));
                        end
                        8:
                        begin
                            // control bytes outside tab, LF and CR, and DEL
                            roll = $urandom_range(29, 0);
                            if (roll < 9)
                                queue_byte(8'(roll));
                            else if (roll < 11)
                                queue_byte(8'(8'h0B + roll - 9));
                            else if (roll < 29)
                                queue_byte(8'(8'h0E + roll - 11));
                            else
                                queue_byte(8'h7F);
                        end
                        default: queue_byte(rnd_byte(8'hE1, 8'hEC));  // lone lead, maybe at the end
                    endcase
                end
                if (i != n_chars)
                begin
                    roll = $urandom_range(99, 0);
                    if (roll < 35)
                        queue_byte(rnd_byte(8'h20, 8'h7E));
                    else if (roll < 40)
                        queue_byte(($urandom_range(1, 0) != 0) ? 8'h09 : 8'h0D);
                    else if (roll < 50)
                        queue_byte(LineFeed);
                    else if (roll < 65)
                    begin
                        queue_byte(rnd_byte(8'hC2, 8'hDF));
                        queue_byte(rnd_byte(8'h80, 8'hBF));
                    end
                    else if (roll < 82)
                    begin
                        case ($urandom_range(3, 0))
                            0:
                            begin
                                queue_byte(8'hE0);
                                queue_byte(rnd_byte(8'hA0, 8'hBF));
                            end
                            1:
                            begin
                                queue_byte(8'hED);
                                queue_byte(rnd_byte(8'h80, 8'h9F));
                            end
                            default:
                            begin
                                lead = rnd_byte(8'hE1, 8'hEE);
                                if (lead == 8'hED)
                                    lead = 8'hEF;
                                queue_byte(lead);
                                queue_byte(rnd_byte(8'h80, 8'hBF));
                            end
                        endcase
                        queue_byte(rnd_byte(8'h80, 8'hBF));
                    end
                    else
                    begin
                        case ($urandom_range(2, 0))
                            0:
                            begin
                                queue_byte(8'hF0);
                                queue_byte(rnd_byte(8'h90, 8'hBF));
                            end
                            1:
                            begin
                                queue_byte(8'hF4);
                                queue_byte(rnd_byte(8'h80, 8'h8F));
                            end
                            default:
                            begin
                                queue_byte(rnd_byte(8'hF1, 8'hF3));
                                queue_byte(rnd_byte(8'h80, 8'hBF));
                            end
                        endcase
                        queue_byte(rnd_byte(8'h80, 8'hBF));
                        queue_byte(rnd_byte(8'h80, 8'hBF));
                    end
                end
            end
            queue_end();
        end
    endtask

    // Wait until every request is taken and every verdict is in, then let byte
    // requests still in flight settle. Sample at the falling edge to stay clear of
    // the clocked blocks.
    task automatic await_idle();
        do
            @(negedge clk);
        while (byte_requests.size() != 0 || in_valid || expected_verdicts.size() != 0);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // Write the line limit through the APB port, then read it back.
    task automatic program_line_limit(input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LinesAddr;
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lines_limit = value;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[15:0] !== value)
            report_mismatch($sformatf("line limit read back %0d, wrote %0d", prdata[15:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------- request driver
    // Fold each accepted request into the prediction, then offer the next one from
    // the queue after its gap. Hold the payload while the block is not ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            data_byte   <= 8'h00;
            end_of_text <= 1'b0;
            send_gap    = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_text_request(data_byte, end_of_text);
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (byte_requests.size() != 0)
                begin
                    next_req = byte_requests.pop_front();
                    in_valid    <= 1'b1;
                    data_byte   <= next_req.data;
                    end_of_text <= next_req.last;
                    send_gap    = next_gap(send_steady);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- verdict monitor
    // Compare each taken verdict with the oldest one owed. Twice in the run, drop
    // ready for a long stretch so that a second end request backs up the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            ready_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                verdicts_seen++;
                if (expected_verdicts.size() == 0)
                    report_mismatch($sformatf("verdict %0d (utf8 %0b, bom %0b) not expected",
                                              verdicts_seen, text_is_utf8, bom_found));
                else
                begin
                    next_verdict_check(expected_verdicts.pop_front());
                end
                if (verdicts_seen == 12 || verdicts_seen == 45)
                    hold_left = LongHoldCycles;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (ready_gap != 0)
            begin
                ready_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                ready_gap = next_gap(ready_steady);
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles == WatchdogLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------- stimulus
    initial
    begin
        int unsigned round;
        int unsigned round_goal;
        logic [15:0] round_limit;
        clear_text_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed texts at the reset line limit.
        // byte-order mark wins even over a byte that fails the check
        queue_byte(8'hEF);
        queue_byte(8'hBB);
        queue_byte(8'hBF);
        queue_byte(8'hFF);
        queue_end();
        // shorter than the mark, and ends inside a sequence
        queue_byte(8'hEF);
        queue_byte(8'hBB);
        queue_end();
        // zero byte is not a character and does not end the text
        queue_byte(8'h00);
        queue_end();
        // highest code point, then a carriage return
        queue_byte(8'hF4);
        queue_byte(8'h8F);
        queue_byte(8'hBF);
        queue_byte(8'hBF);
        queue_byte(8'h0D);
        queue_end();
        // newline inside a two-byte sequence
        queue_byte(8'hC3);
        queue_byte(LineFeed);
        queue_end();
        // one finished line, then leave the text open across a register change
        queue_byte(8'h41);
        queue_byte(LineFeed);
        queue_byte(8'h7E);
        await_idle();

        // lower the limit mid-text: checking has already stopped, so the bad byte is ignored
        program_line_limit(16'd1);
        queue_byte(8'hFF);
        queue_end();
        await_idle();

        // zero lines to check: nothing is checked, not even an open sequence
        program_line_limit(16'd0);
        queue_byte(8'hC3);
        queue_end();
        await_idle();

        // Random texts under a spread of line limits, extremes included.
        for (round = 0; round < 8; round++)
        begin
            case (round)
                0:       round_limit = 16'hFFFF;
                1:       round_limit = 16'd3;
                2:       round_limit = 16'd1;
                3:       round_limit = 16'd10;
                4:       round_limit = 16'd0;
                5:       round_limit = 16'd2;
                6:       round_limit = 16'($urandom_range(20, 5));
                default: round_limit = 16'd4;
            endcase
            program_line_limit(round_limit);
            round_goal = items_queued + 120;
            while (items_queued < round_goal)
                queue_random_text();
            await_idle();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
